// ===== rtl/core/rk4_pkg.sv =====
// ============================================================================
// rk4_pkg: shared types, constants and helpers of the RK4 ODE stepper
// Fixed-point format, register codes, the micro-op program of one step and
// the saturating clip and the output conversion used by the top level.
// ============================================================================
package rk4_pkg;

  // Signed fixed-point word, FRAC_BITS of it fractional.
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 20;
  localparam int OUT_BITS  = 32;
  localparam int CFG_BITS  = 32;
  localparam int STEP_BITS = 31;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Reciprocal of six, rounded to nearest.
  localparam word_t SIXTH = word_t'(((64'd1 << FRAC_BITS) + 64'd3) / 64'd6);

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_STEP_SIZE = 3'd0,
    CFG_START_X   = 3'd1,
    CFG_START_Y   = 3'd2,
    CFG_START_Z   = 3'd3,
    CFG_END_X     = 3'd4
  } cfg_idx_t;

  localparam logic [STEP_BITS-1:0] STEP_SIZE_RST = 31'd5243;
  localparam logic [CFG_BITS-1:0]  START_X_RST   = 32'd0;
  localparam logic [CFG_BITS-1:0]  START_Y_RST   = 32'd3145728;
  localparam logic [CFG_BITS-1:0]  START_Z_RST   = 32'd4194304;
  localparam logic [CFG_BITS-1:0]  END_X_RST     = 32'd2097152;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,  // saturating a + b
    OP_SUB  = 2'd1,  // saturating a - b
    OP_MULH = 2'd2,  // a * b >> (FRAC_BITS + 1), rounded, saturated
    OP_MULF = 2'd3   // a * b >> FRAC_BITS, rounded, saturated
  } alu_op_t;

  // Working registers addressed by the micro-op program.
  typedef enum logic [3:0] {
    R_X   = 4'd0,
    R_Y   = 4'd1,
    R_Z   = 4'd2,
    R_H   = 4'd3,
    R_SIX = 4'd4,
    R_TMP = 4'd5,
    R_ACC = 4'd6,
    R_B   = 4'd7,
    R_C   = 4'd8,
    R_YK  = 4'd9,
    R_C1  = 4'd10,
    R_B2D = 4'd11,
    R_B3D = 4'd12,
    R_C2D = 4'd13,
    R_C3D = 4'd14
  } reg_sel_t;

  typedef struct packed {
    alu_op_t  op;
    reg_sel_t dst;
    reg_sel_t src_a;
    reg_sel_t src_b;
  } uop_t;

  // Request to the shared unit.
  typedef struct packed {
    alu_op_t op;
    word_t   a;
    word_t   b;
  } alu_req_t;

  // A value together with its clip flag.
  typedef struct packed {
    word_t val;
    logic  sat;
  } res_t;

  localparam int PROG_LEN = 45;
  localparam int PC_W     = $clog2(PROG_LEN);

  // One RK4 step. b1 is z itself; b holds b2..b4 in turn, c holds c2..c4.
  localparam uop_t PROG [PROG_LEN] = '{
    // k1: c1 = 3z - 2y
    '{OP_ADD,  R_TMP, R_Z,   R_Z},
    '{OP_ADD,  R_TMP, R_TMP, R_Z},
    '{OP_ADD,  R_ACC, R_Y,   R_Y},
    '{OP_SUB,  R_C1,  R_TMP, R_ACC},
    // k2: b2 = z + h*c1/2, y2 = y + h*b1/2
    '{OP_MULH, R_TMP, R_H,   R_C1},
    '{OP_ADD,  R_B,   R_Z,   R_TMP},
    '{OP_MULH, R_TMP, R_H,   R_Z},
    '{OP_ADD,  R_YK,  R_Y,   R_TMP},
    '{OP_ADD,  R_TMP, R_B,   R_B},
    '{OP_ADD,  R_TMP, R_TMP, R_B},
    '{OP_ADD,  R_ACC, R_YK,  R_YK},
    '{OP_SUB,  R_C,   R_TMP, R_ACC},
    '{OP_ADD,  R_B2D, R_B,   R_B},
    '{OP_ADD,  R_C2D, R_C,   R_C},
    // k3: b3 = z + h*c2/2, y3 = y + h*b2/2
    '{OP_MULH, R_TMP, R_H,   R_C},
    '{OP_MULH, R_ACC, R_H,   R_B},
    '{OP_ADD,  R_B,   R_Z,   R_TMP},
    '{OP_ADD,  R_YK,  R_Y,   R_ACC},
    '{OP_ADD,  R_TMP, R_B,   R_B},
    '{OP_ADD,  R_TMP, R_TMP, R_B},
    '{OP_ADD,  R_ACC, R_YK,  R_YK},
    '{OP_SUB,  R_C,   R_TMP, R_ACC},
    '{OP_ADD,  R_B3D, R_B,   R_B},
    '{OP_ADD,  R_C3D, R_C,   R_C},
    // k4: b4 = z + h*c3, y4 = y + h*b3
    '{OP_MULF, R_TMP, R_H,   R_C},
    '{OP_MULF, R_ACC, R_H,   R_B},
    '{OP_ADD,  R_B,   R_Z,   R_TMP},
    '{OP_ADD,  R_YK,  R_Y,   R_ACC},
    '{OP_ADD,  R_TMP, R_B,   R_B},
    '{OP_ADD,  R_TMP, R_TMP, R_B},
    '{OP_ADD,  R_ACC, R_YK,  R_YK},
    '{OP_SUB,  R_C,   R_TMP, R_ACC},
    // y update from b1 + b4 + 2b2 + 2b3
    '{OP_ADD,  R_TMP, R_Z,   R_B},
    '{OP_ADD,  R_TMP, R_TMP, R_B2D},
    '{OP_ADD,  R_TMP, R_TMP, R_B3D},
    '{OP_MULF, R_TMP, R_H,   R_TMP},
    '{OP_MULF, R_TMP, R_TMP, R_SIX},
    '{OP_ADD,  R_Y,   R_Y,   R_TMP},
    // z update from c1 + c4 + 2c2 + 2c3
    '{OP_ADD,  R_TMP, R_C1,  R_C},
    '{OP_ADD,  R_TMP, R_TMP, R_C2D},
    '{OP_ADD,  R_TMP, R_TMP, R_C3D},
    '{OP_MULF, R_TMP, R_H,   R_TMP},
    '{OP_MULF, R_TMP, R_TMP, R_SIX},
    '{OP_ADD,  R_Z,   R_Z,   R_TMP},
    // advance x
    '{OP_ADD,  R_X,   R_X,   R_H}
  };

  // Clip a register value into the word range.
  function automatic res_t clip_reg(input logic signed [CFG_BITS:0] v);
    logic signed [64:0] e;
    res_t r;
    e = 65'(v);
    if (e > 65'(WORD_MAX)) begin
      r.val = WORD_MAX;
      r.sat = 1'b1;
    end else if (e < 65'(WORD_MIN)) begin
      r.val = WORD_MIN;
      r.sat = 1'b1;
    end else begin
      r.val = word_t'(e);
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // Low output bits of a word, sign-extended when the word is narrower.
  function automatic logic [OUT_BITS-1:0] to_out(input word_t w);
    logic signed [63:0] e;
    e = 64'(w);
    return e[OUT_BITS-1:0];
  endfunction

endpackage

// ===== rtl/core/rk4_alu.sv =====
// ============================================================================
// rk4_alu: shared saturating adder and rounding multiplier
// The adder answers in the same cycle. The multiplier registers the full
// product; rounding, shifting and clipping follow in the next cycle.
// ============================================================================
module rk4_alu (
  input  logic              clk,
  input  rk4_pkg::alu_req_t req,
  input  logic              mul_go,
  output rk4_pkg::res_t     sum_res,
  output rk4_pkg::res_t     mul_res
);

  localparam int W  = rk4_pkg::WORD_BITS;
  localparam int F  = rk4_pkg::FRAC_BITS;
  localparam int QW = 2 * W + 1;

  localparam logic [QW-1:0] RND_H = QW'(1) << F;
  localparam logic [QW-1:0] RND_F = QW'(1) << (F - 1);
  localparam logic [QW-1:0] QMAX  = (QW'(1) << (W - 1)) - QW'(1);
  localparam logic [QW-1:0] QLIM  = QW'(1) << (W - 1);

  logic signed [W:0]     sum_ext;
  logic signed [2*W-1:0] prod;
  logic                  half_q;
  logic [2*W-1:0]        mag;
  logic [QW-1:0]         rnd;
  logic [QW-1:0]         q;
  logic                  neg;

  // Saturating add or subtract: overflow shows as a mismatch of the top bits.
  always_comb begin
    if (req.op == rk4_pkg::OP_SUB) begin
      sum_ext = {req.a[W-1], req.a} - {req.b[W-1], req.b};
    end else begin
      sum_ext = {req.a[W-1], req.a} + {req.b[W-1], req.b};
    end
    if (sum_ext[W] != sum_ext[W-1]) begin
      sum_res.val = sum_ext[W] ? rk4_pkg::WORD_MIN : rk4_pkg::WORD_MAX;
      sum_res.sat = 1'b1;
    end else begin
      sum_res.val = sum_ext[W-1:0];
      sum_res.sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_go) begin
      prod   <= req.a * req.b;
      half_q <= (req.op == rk4_pkg::OP_MULH);
    end
  end

  // Round the magnitude half away from zero, then restore the sign.
  always_comb begin
    neg = prod[2*W-1];
    mag = neg ? (2*W)'(-prod) : (2*W)'(prod);
    rnd = {1'b0, mag} + (half_q ? RND_H : RND_F);
    q   = half_q ? (rnd >> (F + 1)) : (rnd >> F);
    if (!neg) begin
      if (q > QMAX) begin
        mul_res.val = rk4_pkg::WORD_MAX;
        mul_res.sat = 1'b1;
      end else begin
        mul_res.val = q[W-1:0];
        mul_res.sat = 1'b0;
      end
    end else begin
      if (q > QLIM) begin
        mul_res.val = rk4_pkg::WORD_MIN;
        mul_res.sat = 1'b1;
      end else begin
        mul_res.val = -q[W-1:0];
        mul_res.sat = 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/rk4_linear_ode2_step.sv =====
// ============================================================================
// rk4_linear_ode2_step: fixed-point RK4 stepper for y' = z, z' = 3z - 2y
// A step beat runs 45 micro-ops on one shared unit, ten of them multiplies
// that pass through a write-back state, and then the limit compare. A restart
// beat skips the program and returns its result through the limit compare.
// One beat is in flight at a time; the next is taken after the result leaves.
// Reset restores the register defaults and loads x, y and z from them.
// ============================================================================
module rk4_linear_ode2_step (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // Input channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        restart,
  // Output channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] x_pos,
  output logic [31:0] y_val,
  output logic [31:0] z_val,
  output logic        finished,
  output logic        saturated
);

  // The sequencer walks the micro-op program one entry at a time. Adds and
  // subtracts complete in the cycle they are issued; a multiply is issued in
  // EXEC and written back from MULW, where the rounding stage of the unit
  // produces its value. FIN compares the new x with the limit and OUT holds
  // the result beat until it is taken.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_MULW = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state;
  logic [rk4_pkg::PC_W-1:0] pc;

  // Configuration registers.
  logic [rk4_pkg::STEP_BITS-1:0] step_size;
  logic [rk4_pkg::CFG_BITS-1:0]  start_x;
  logic [rk4_pkg::CFG_BITS-1:0]  start_y;
  logic [rk4_pkg::CFG_BITS-1:0]  start_z;
  logic [rk4_pkg::CFG_BITS-1:0]  end_x;

  // Integrator state and working registers.
  rk4_pkg::word_t x, y, z, h;
  rk4_pkg::word_t tmp, acc, b, c, yk, c1, b2d, b3d, c2d, c3d;

  rk4_pkg::uop_t     uop;
  rk4_pkg::alu_req_t req;
  rk4_pkg::res_t     sum_res, mul_res, wb_res;
  rk4_pkg::res_t     sx, sy, sz, hc, lc;
  logic              is_mul, wb_en, last_op;

  // Register values clipped into the word range. With a 32-bit word only a
  // narrower configuration of the word can make these clip.
  assign sx = rk4_pkg::clip_reg($signed({start_x[rk4_pkg::CFG_BITS-1], start_x}));
  assign sy = rk4_pkg::clip_reg($signed({start_y[rk4_pkg::CFG_BITS-1], start_y}));
  assign sz = rk4_pkg::clip_reg($signed({start_z[rk4_pkg::CFG_BITS-1], start_z}));
  assign lc = rk4_pkg::clip_reg($signed({end_x[rk4_pkg::CFG_BITS-1], end_x}));
  assign hc = rk4_pkg::clip_reg($signed({2'b00, step_size}));

  assign uop     = rk4_pkg::PROG[pc];
  assign is_mul  = (uop.op == rk4_pkg::OP_MULH) || (uop.op == rk4_pkg::OP_MULF);
  assign last_op = (pc == rk4_pkg::PC_W'(rk4_pkg::PROG_LEN - 1));
  assign wb_en   = ((state == ST_EXEC) && !is_mul) || (state == ST_MULW);
  assign wb_res  = (state == ST_MULW) ? mul_res : sum_res;

  assign req.op = uop.op;

  // Operand A select.
  always_comb begin
    unique case (uop.src_a)
      rk4_pkg::R_X:   req.a = x;
      rk4_pkg::R_Y:   req.a = y;
      rk4_pkg::R_Z:   req.a = z;
      rk4_pkg::R_H:   req.a = h;
      rk4_pkg::R_SIX: req.a = rk4_pkg::SIXTH;
      rk4_pkg::R_TMP: req.a = tmp;
      rk4_pkg::R_ACC: req.a = acc;
      rk4_pkg::R_B:   req.a = b;
      rk4_pkg::R_C:   req.a = c;
      rk4_pkg::R_YK:  req.a = yk;
      rk4_pkg::R_C1:  req.a = c1;
      rk4_pkg::R_B2D: req.a = b2d;
      rk4_pkg::R_B3D: req.a = b3d;
      rk4_pkg::R_C2D: req.a = c2d;
      rk4_pkg::R_C3D: req.a = c3d;
      default:        req.a = '0;
    endcase
  end

  // Operand B select.
  always_comb begin
    unique case (uop.src_b)
      rk4_pkg::R_X:   req.b = x;
      rk4_pkg::R_Y:   req.b = y;
      rk4_pkg::R_Z:   req.b = z;
      rk4_pkg::R_H:   req.b = h;
      rk4_pkg::R_SIX: req.b = rk4_pkg::SIXTH;
      rk4_pkg::R_TMP: req.b = tmp;
      rk4_pkg::R_ACC: req.b = acc;
      rk4_pkg::R_B:   req.b = b;
      rk4_pkg::R_C:   req.b = c;
      rk4_pkg::R_YK:  req.b = yk;
      rk4_pkg::R_C1:  req.b = c1;
      rk4_pkg::R_B2D: req.b = b2d;
      rk4_pkg::R_B3D: req.b = b3d;
      rk4_pkg::R_C2D: req.b = c2d;
      rk4_pkg::R_C3D: req.b = c3d;
      default:        req.b = '0;
    endcase
  end

  rk4_alu u_alu (
    .clk     (clk),
    .req     (req),
    .mul_go  ((state == ST_EXEC) && is_mul),
    .sum_res (sum_res),
    .mul_res (mul_res)
  );

  // Control, configuration and the integrator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= '0;
      finished  <= 1'b0;
      saturated <= 1'b0;
      step_size <= rk4_pkg::STEP_SIZE_RST;
      start_x   <= rk4_pkg::START_X_RST;
      start_y   <= rk4_pkg::START_Y_RST;
      start_z   <= rk4_pkg::START_Z_RST;
      end_x     <= rk4_pkg::END_X_RST;
      x <= rk4_pkg::clip_reg($signed({rk4_pkg::START_X_RST[31], rk4_pkg::START_X_RST})).val;
      y <= rk4_pkg::clip_reg($signed({rk4_pkg::START_Y_RST[31], rk4_pkg::START_Y_RST})).val;
      z <= rk4_pkg::clip_reg($signed({rk4_pkg::START_Z_RST[31], rk4_pkg::START_Z_RST})).val;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rk4_pkg::CFG_STEP_SIZE: step_size <= cfg_data[rk4_pkg::STEP_BITS-1:0];
          rk4_pkg::CFG_START_X:   start_x   <= cfg_data;
          rk4_pkg::CFG_START_Y:   start_y   <= cfg_data;
          rk4_pkg::CFG_START_Z:   start_z   <= cfg_data;
          rk4_pkg::CFG_END_X:     end_x     <= cfg_data;
          default: ;
        endcase
      end

      // Program writes to the state registers.
      if (wb_en) begin
        unique case (uop.dst)
          rk4_pkg::R_X: x <= wb_res.val;
          rk4_pkg::R_Y: y <= wb_res.val;
          rk4_pkg::R_Z: z <= wb_res.val;
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (restart) begin
              x         <= sx.val;
              y         <= sy.val;
              z         <= sz.val;
              saturated <= sx.sat | sy.sat | sz.sat;
              state     <= ST_FIN;
            end else begin
              saturated <= hc.sat;
              pc        <= '0;
              state     <= ST_EXEC;
            end
          end
        end
        ST_EXEC, ST_MULW: begin
          if ((state == ST_EXEC) && is_mul) begin
            state <= ST_MULW;
          end else begin
            saturated <= saturated | wb_res.sat;
            if (last_op) begin
              state <= ST_FIN;
            end else begin
              pc    <= pc + 1'b1;
              state <= ST_EXEC;
            end
          end
        end
        ST_FIN: begin
          finished  <= (x > lc.val);
          saturated <= saturated | lc.sat;
          state     <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Step size is captured when a step beat is accepted.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && in_valid && !restart) begin
      h <= hc.val;
    end
  end

  // Scratch registers written by the program.
  always_ff @(posedge clk) begin
    if (wb_en) begin
      unique case (uop.dst)
        rk4_pkg::R_TMP: tmp <= wb_res.val;
        rk4_pkg::R_ACC: acc <= wb_res.val;
        rk4_pkg::R_B:   b   <= wb_res.val;
        rk4_pkg::R_C:   c   <= wb_res.val;
        rk4_pkg::R_YK:  yk  <= wb_res.val;
        rk4_pkg::R_C1:  c1  <= wb_res.val;
        rk4_pkg::R_B2D: b2d <= wb_res.val;
        rk4_pkg::R_B3D: b3d <= wb_res.val;
        rk4_pkg::R_C2D: c2d <= wb_res.val;
        rk4_pkg::R_C3D: c3d <= wb_res.val;
        default: ;
      endcase
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign x_pos     = rk4_pkg::to_out(x);
  assign y_val     = rk4_pkg::to_out(y);
  assign z_val     = rk4_pkg::to_out(z);

  // The block never takes an input beat while a result beat is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  // A step beat starts the program at its first entry.
  a_step_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !restart) |=> (state == ST_EXEC && pc == '0))
    else $error("step did not start at the first micro-op");

  // A restart beat skips the program and goes to the limit compare.
  a_restart_fin: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && restart) |=> (state == ST_FIN))
    else $error("restart did not go straight to the limit compare");

  // A multiply write-back always follows the issue of a multiply.
  a_mul_issue: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MULW) |-> ($past(state) == ST_EXEC && $stable(pc)))
    else $error("multiply write-back without an issue");

endmodule

// ===== dv/rk4_linear_ode2_step_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// rk4_linear_ode2_step_tb: self-checking bench for the fixed-point RK4 stepper
// A table of directed beats covers reset values, the zero step, unmapped
// register writes and the word extremes. A long random run follows, made of
// restart-then-step sequences under changing settings and handshake pressure.
// Every result beat is compared with the result typed into the table or else
// with a cycle-free fixed-point model of the integrator kept inside this bench.
// ============================================================================
module rk4_linear_ode2_step_tb;

  // Number of random input beats after the directed table.
  localparam int RUN_BEATS = 1950;

  // Fraction bits of the working word.
  localparam int FRAC_BITS = rk4_pkg::FRAC_BITS;

  // Saturation bounds of the 32-bit working word.
  localparam longint WORD_HI = 64'sd2147483647;
  localparam longint WORD_LO = -64'sd2147483648;
  // Reciprocal of six in the working format, rounded to nearest.
  localparam longint ONE_SIXTH = ((64'sd1 <<< FRAC_BITS) + 3) / 6;

  // Register values after reset.
  localparam logic [30:0] RST_STEP    = 31'd5243;
  localparam logic [31:0] RST_START_X = 32'd0;
  localparam logic [31:0] RST_START_Y = 32'h0030_0000;
  localparam logic [31:0] RST_START_Z = 32'h0040_0000;
  localparam logic [31:0] RST_END_X   = 32'h0020_0000;

  // Indexes that the port can carry but that select no register.
  localparam logic [2:0] CFG_SPARE_5 = 3'd5;
  localparam logic [2:0] CFG_SPARE_6 = 3'd6;
  localparam logic [2:0] CFG_SPARE_7 = 3'd7;

  // One result beat: the solution point after an input beat.
  typedef struct packed {
    logic [31:0] x_pos;
    logic [31:0] y_val;
    logic [31:0] z_val;
    logic        finished;
    logic        saturated;
  } ode_point_t;

  // A result typed into the directed table, when there is one for the beat.
  typedef struct packed {
    logic       known;
    ode_point_t pt;
  } point_note_t;

  typedef enum logic [1:0] {
    ROW_CFG,    // register write, done while the block is idle
    ROW_BEAT,   // input beat checked against the model
    ROW_KNOWN   // input beat with its result typed in
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [31:0] data;
    logic        reload;
    ode_point_t  pt;
  } stim_row_t;

  // Restart result with every register at its reset value.
  localparam ode_point_t DEFAULT_POINT =
    '{32'h0000_0000, 32'h0030_0000, 32'h0040_0000, 1'b0, 1'b0};

  // ---------------------------------------------------------------------------
  // DUT and its drive. Every input has a known value from time zero.
  // ---------------------------------------------------------------------------
  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic        restart   = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] x_pos;
  logic [31:0] y_val;
  logic [31:0] z_val;
  logic        finished;
  logic        saturated;

  rk4_linear_ode2_step dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .x_pos     (x_pos),
    .y_val     (y_val),
    .z_val     (z_val),
    .finished  (finished),
    .saturated (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs. The slowest legal run is far shorter.
  initial begin
    #(4_000_000);
    $display("rk4_linear_ode2_step verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Model state: register copies, the solution point and the clip flag.
  // ---------------------------------------------------------------------------
  logic [30:0] cfg_h;
  logic [31:0] cfg_x0, cfg_y0, cfg_z0, cfg_xend;
  longint      sol_x, sol_y, sol_z;
  logic        clip_hit;

  ode_point_t  pending_points [$];   // results still owed by the block
  point_note_t preset_points [$];    // typed results, one note per input beat
  int          mismatch_count = 0;
  int          beats_sent = 0;

  // Handshake pressure, in percent of cycles.
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;

  function automatic longint clamp_word(input longint v);
    if (v > WORD_HI) begin
      clip_hit = 1'b1;
      return WORD_HI;
    end
    if (v < WORD_LO) begin
      clip_hit = 1'b1;
      return WORD_LO;
    end
    return v;
  endfunction

  function automatic longint sat_add(input longint a, input longint b);
    return clamp_word(a + b);
  endfunction

  function automatic longint sat_sub(input longint a, input longint b);
    return clamp_word(a - b);
  endfunction

  // Product shifted right by sh. The magnitude is rounded to nearest, so a
  // half rounds away from zero, and the signed result is then saturated.
  function automatic longint mul_round(input longint a, input longint b, input int sh);
    logic [63:0] mag_a, mag_b, q;
    logic        neg;
    neg   = (a < 0) != (b < 0);
    mag_a = (a < 0) ? -a : a;
    mag_b = (b < 0) ? -b : b;
    q     = (mag_a * mag_b + (64'd1 << (sh - 1))) >> sh;
    if (!neg) begin
      if (q > 64'h7FFF_FFFF) begin
        clip_hit = 1'b1;
        return WORD_HI;
      end
      return longint'(q);
    end
    if (q > 64'h8000_0000) begin
      clip_hit = 1'b1;
      return WORD_LO;
    end
    return -longint'(q);
  endfunction

  // Slope of z: 3z - 2y, built from saturating additions.
  function automatic longint slope_z(input longint y, input longint z);
    return sat_sub(sat_add(sat_add(z, z), z), sat_add(y, y));
  endfunction

  // Applies one input beat to the model state and returns the result beat.
  function automatic ode_point_t rk4_advance(input logic reload);
    longint     h, y, z, b1, c1, b2, c2, b3, c3, b4, c4, sum_b, sum_c;
    ode_point_t pt;
    clip_hit = 1'b0;
    if (reload) begin
      sol_x = longint'($signed(cfg_x0));
      sol_y = longint'($signed(cfg_y0));
      sol_z = longint'($signed(cfg_z0));
    end else begin
      h  = longint'(cfg_h);
      y  = sol_y;
      z  = sol_z;
      b1 = z;
      c1 = slope_z(y, z);
      b2 = sat_add(z, mul_round(h, c1, FRAC_BITS + 1));
      c2 = slope_z(sat_add(y, mul_round(h, b1, FRAC_BITS + 1)), b2);
      b3 = sat_add(z, mul_round(h, c2, FRAC_BITS + 1));
      c3 = slope_z(sat_add(y, mul_round(h, b2, FRAC_BITS + 1)), b3);
      b4 = sat_add(z, mul_round(h, c3, FRAC_BITS));
      c4 = slope_z(sat_add(y, mul_round(h, b3, FRAC_BITS)), b4);
      sum_b = sat_add(sat_add(sat_add(b1, b4), sat_add(b2, b2)), sat_add(b3, b3));
      sum_c = sat_add(sat_add(sat_add(c1, c4), sat_add(c2, c2)), sat_add(c3, c3));
      sol_y = sat_add(y, mul_round(mul_round(h, sum_b, FRAC_BITS), ONE_SIXTH, FRAC_BITS));
      sol_z = sat_add(z, mul_round(mul_round(h, sum_c, FRAC_BITS), ONE_SIXTH, FRAC_BITS));
      sol_x = sat_add(sol_x, h);
    end
    pt.x_pos     = sol_x[31:0];
    pt.y_val     = sol_y[31:0];
    pt.z_val     = sol_z[31:0];
    pt.finished  = sol_x > longint'($signed(cfg_xend));
    pt.saturated = clip_hit;
    return pt;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge, before the block and
  // the drivers update, so register writes, accepted input beats and result
  // beats are seen exactly as the block sees them.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    ode_point_t  fresh, want;
    point_note_t note;
    if (rst) begin
      cfg_h    = RST_STEP;
      cfg_x0   = RST_START_X;
      cfg_y0   = RST_START_Y;
      cfg_z0   = RST_START_Z;
      cfg_xend = RST_END_X;
      sol_x    = longint'($signed(RST_START_X));
      sol_y    = longint'($signed(RST_START_Y));
      sol_z    = longint'($signed(RST_START_Z));
    end else begin
      if (cfg_we) begin
        // The step register keeps only its low 31 bits. Spare indexes are
        // ignored by the block.
        case (cfg_index)
          rk4_pkg::CFG_STEP_SIZE: cfg_h    = cfg_data[30:0];
          rk4_pkg::CFG_START_X:   cfg_x0   = cfg_data;
          rk4_pkg::CFG_START_Y:   cfg_y0   = cfg_data;
          rk4_pkg::CFG_START_Z:   cfg_z0   = cfg_data;
          rk4_pkg::CFG_END_X:     cfg_xend = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        // The model always advances; a typed result, when the table has
        // one, replaces the computed one as the expectation.
        fresh = rk4_advance(restart);
        note  = preset_points.pop_front();
        pending_points.push_back(note.known ? note.pt : fresh);
      end
      if (out_valid && out_ready) begin
        if (pending_points.size() == 0) begin
          report_mismatch("result beat with nothing expected", x_pos, '0);
        end else begin
          want = pending_points.pop_front();
          if (x_pos !== want.x_pos) report_mismatch("x_pos", x_pos, want.x_pos);
          if (y_val !== want.y_val) report_mismatch("y_val", y_val, want.y_val);
          if (z_val !== want.z_val) report_mismatch("z_val", z_val, want.z_val);
          if (finished !== want.finished)
            report_mismatch("finished", 32'(finished), 32'(want.finished));
          if (saturated !== want.saturated)
            report_mismatch("saturated", 32'(saturated), 32'(want.saturated));
        end
      end
    end
  end

  // Receiver: out_ready is redrawn every cycle against the current stall rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Driver tasks.
  // ---------------------------------------------------------------------------

  // Sends one input beat and returns at the edge that accepts it. in_valid is
  // left high, so a following beat with no gap goes out back to back.
  task automatic send_beat(input logic reload, input logic known, input ode_point_t pt);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < tx_idle_pct) gap++;
    preset_points.push_back('{known, pt});
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= reload;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // Drops in_valid and waits until every owed result beat has left the block.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Start values: mostly within +-8.0, sometimes a word extreme or anything.
  function automatic logic [31:0] pick_start();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return $urandom;
      default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
    endcase
  endfunction

  // Step sizes: mostly small, so that runs stay accurate for a while; large
  // and extreme steps drive the state into saturation quickly.
  function automatic logic [31:0] pick_step();
    case ($urandom_range(19))
      0:          return 32'h0000_0000;
      1:          return 32'h7FFF_FFFF;
      2, 3:       return $urandom;
      4, 5, 6:    return $urandom_range(1, 32'h0040_0000);
      default:    return $urandom_range(1, 20000);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Rows with a typed result need no arithmetic: restarts,
  // and steps of size zero, where only the slope sums may clip.
  // ---------------------------------------------------------------------------
  localparam int DIRECTED_ROWS = 37;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // Restart straight after reset returns the reset values.
    '{ROW_KNOWN, '0, '0, 1'b1, DEFAULT_POINT},
    '{ROW_BEAT,  '0, '0, 1'b0, '0},
    '{ROW_BEAT,  '0, '0, 1'b0, '0},
    '{ROW_BEAT,  '0, '0, 1'b1, '0},
    // Zero step leaves the point where it is.
    '{ROW_CFG,   rk4_pkg::CFG_STEP_SIZE, 32'h0000_0000, 1'b0, '0},
    '{ROW_KNOWN, '0, '0, 1'b0, DEFAULT_POINT},
    // Writes to spare indexes must change nothing.
    '{ROW_CFG,   CFG_SPARE_5, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_CFG,   CFG_SPARE_6, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_CFG,   CFG_SPARE_7, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_KNOWN, '0, '0, 1'b0, DEFAULT_POINT},
    // Extreme start values; x above the lowest limit raises finished.
    '{ROW_CFG,   rk4_pkg::CFG_START_X, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_CFG,   rk4_pkg::CFG_START_Y, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_CFG,   rk4_pkg::CFG_START_Z, 32'h8000_0000, 1'b0, '0},
    '{ROW_CFG,   rk4_pkg::CFG_END_X,   32'h8000_0000, 1'b0, '0},
    '{ROW_KNOWN, '0, '0, 1'b1, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0}},
    // Zero step from there: 3z - 2y clips, the point stays put.
    '{ROW_KNOWN, '0, '0, 1'b0, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1}},
    // All ones into the step register; the top bit is dropped.
    '{ROW_CFG,   rk4_pkg::CFG_STEP_SIZE, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_BEAT,  '0, '0, 1'b0, '0},
    '{ROW_BEAT,  '0, '0, 1'b0, '0},
    // x equal to the highest limit does not count as finished.
    '{ROW_CFG,   rk4_pkg::CFG_END_X,   32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_CFG,   rk4_pkg::CFG_START_Y, 32'h8000_0000, 1'b0, '0},
    '{ROW_CFG,   rk4_pkg::CFG_START_Z, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_KNOWN, '0, '0, 1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0}},
    '{ROW_BEAT,  '0, '0, 1'b0, '0},
    // Smallest x, flat solution, smallest nonzero step.
    '{ROW_CFG,   rk4_pkg::CFG_START_X, 32'h8000_0000, 1'b0, '0},
    '{ROW_CFG,   rk4_pkg::CFG_START_Y, 32'h0000_0000, 1'b0, '0},
    '{ROW_CFG,   rk4_pkg::CFG_START_Z, 32'h0000_0000, 1'b0, '0},
    '{ROW_CFG,   rk4_pkg::CFG_STEP_SIZE, 32'h0000_0001, 1'b0, '0},
    '{ROW_KNOWN, '0, '0, 1'b1, '{32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0}},
    '{ROW_BEAT,  '0, '0, 1'b0, '0},
    // Back to the reset settings.
    '{ROW_CFG,   rk4_pkg::CFG_STEP_SIZE, 32'(RST_STEP), 1'b0, '0},
    '{ROW_CFG,   rk4_pkg::CFG_START_X, RST_START_X, 1'b0, '0},
    '{ROW_CFG,   rk4_pkg::CFG_START_Y, RST_START_Y, 1'b0, '0},
    '{ROW_CFG,   rk4_pkg::CFG_START_Z, RST_START_Z, 1'b0, '0},
    '{ROW_CFG,   rk4_pkg::CFG_END_X,   RST_END_X,   1'b0, '0},
    '{ROW_KNOWN, '0, '0, 1'b1, DEFAULT_POINT},
    '{ROW_BEAT,  '0, '0, 1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int          session;
    int          run_len;
    logic [31:0] x0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CFG: begin
          settle();
          write_reg(directed_rows[i].idx, directed_rows[i].data);
        end
        ROW_BEAT:  send_beat(directed_rows[i].reload, 1'b0, '0);
        ROW_KNOWN: send_beat(directed_rows[i].reload, 1'b1, directed_rows[i].pt);
        default: ;
      endcase
    end

    // Random sessions. Each one changes the settings while the block is
    // idle, usually restarts, and then runs a stretch of steps. A session
    // without a restart carries on from the previous point, so long runs
    // build up and reach saturation. Rare restarts in the middle of a run
    // serve as noise.
    beats_sent = 0;
    session    = 0;
    while (beats_sent < RUN_BEATS) begin
      settle();
      case (session % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 58;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 58;
        end
        default: begin
          tx_idle_pct  = 9;
          rx_stall_pct = 9;
        end
      endcase
      write_reg(rk4_pkg::CFG_STEP_SIZE, pick_step());
      if ($urandom_range(3) != 0) begin
        x0 = pick_start();
        write_reg(rk4_pkg::CFG_START_X, x0);
        write_reg(rk4_pkg::CFG_START_Y, pick_start());
        write_reg(rk4_pkg::CFG_START_Z, pick_start());
        // The limit usually sits a little ahead of the start, so finished
        // changes during the run.
        write_reg(rk4_pkg::CFG_END_X,
                  ($urandom_range(7) == 0) ? pick_start()
                                           : x0 + $urandom_range(0, 32'h0010_0000));
      end
      if ($urandom_range(9) < 7) send_beat(1'b1, 1'b0, '0);
      run_len = $urandom_range(10, 80);
      repeat (run_len) send_beat($urandom_range(19) == 0, 1'b0, '0);
      session++;
    end

    // Drain, then leave time for any stray result beat to show up.
    settle();
    repeat (64) @(posedge clk);

    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("rk4_linear_ode2_step verification clean");
    end else begin
      $display("rk4_linear_ode2_step verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/rk4_pkg.sv
rtl/core/rk4_alu.sv
rtl/core/rk4_linear_ode2_step.sv
dv/rk4_linear_ode2_step_tb.sv
